// ----- rtl/lmis_pkg.sv -----
// ----------------------------------------------------------------------------
// lmis_pkg
// Shared types and constants of the masked intensity statistics block.
// ----------------------------------------------------------------------------
package lmis_pkg;

  // default volume edge length
  localparam int unsigned LmisMaxDimDefault = 1024;

  // count saturates at this many voxels
  localparam logic [30:0] LmisCountCap = 31'h4000_0000;

  // entries of the queue between front and back
  localparam int unsigned LmisQueueDepth = 2;

  // configuration register indexes
  localparam logic [1:0] RegSelectedLevel = 2'd0;
  localparam logic [1:0] RegDomainMode    = 2'd1;
  localparam logic [1:0] RegSlicePosition = 2'd2;

  // domain codes
  typedef enum logic [1:0] {
    DomWhole  = 2'd0,
    DomSliceX = 2'd1,
    DomSliceY = 2'd2,
    DomSliceZ = 2'd3
  } lmis_domain_e;

  // configuration seen by the front
  typedef struct packed {
    logic signed [15:0] selected_level;
    lmis_domain_e       domain_mode;
    logic [9:0]         slice_position;
  } lmis_cfg_t;

  // accumulator snapshot handed from front to back
  typedef struct packed {
    logic [30:0]        count;
    logic signed [45:0] sum;
    logic [60:0]        square_sum;
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
  } lmis_snap_t;

endpackage

// ----- rtl/lmis_vox_if.sv -----
// ----------------------------------------------------------------------------
// lmis_vox_if
// Voxel channel: valid/ready handshake with one voxel per transfer.
// ----------------------------------------------------------------------------
interface lmis_vox_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] label;
  logic signed [15:0] intensity;
  logic [9:0]         coord_x;
  logic [9:0]         coord_y;
  logic [9:0]         coord_z;
  logic               last_voxel;

  modport source (
    output valid, label, intensity, coord_x, coord_y, coord_z, last_voxel,
    input  ready
  );
  modport sink (
    input  valid, label, intensity, coord_x, coord_y, coord_z, last_voxel,
    output ready
  );
endinterface

// ----- rtl/lmis_res_if.sv -----
// ----------------------------------------------------------------------------
// lmis_res_if
// Result channel: valid/ready handshake with one statistics record per transfer.
// ----------------------------------------------------------------------------
interface lmis_res_if;
  logic               valid;
  logic               ready;
  logic [30:0]        voxel_count;
  logic signed [23:0] mean_q8;
  logic [23:0]        std_q8;
  logic signed [15:0] min_value;
  logic signed [15:0] max_value;

  modport source (
    output valid, voxel_count, mean_q8, std_q8, min_value, max_value,
    input  ready
  );
  modport sink (
    input  valid, voxel_count, mean_q8, std_q8, min_value, max_value,
    output ready
  );
endinterface

// ----- rtl/lmis_front.sv -----
// ----------------------------------------------------------------------------
// lmis_front
// Voxel classification and running accumulation; pushes a snapshot on the
// last voxel of a volume and clears.
// ----------------------------------------------------------------------------
module lmis_front #(
  parameter int unsigned MaxDim = lmis_pkg::LmisMaxDimDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lmis_pkg::lmis_cfg_t    cfg_i,
  lmis_vox_if.sink               vox_i,
  output logic                   push_o,
  output lmis_pkg::lmis_snap_t   snap_o,
  input  logic                   push_ready_i
);
  import lmis_pkg::*;

  logic [30:0]        count_q, count_d;
  logic signed [45:0] sum_q, sum_d;
  logic [60:0]        sqsum_q, sqsum_d;
  logic signed [15:0] min_q, min_d;
  logic signed [15:0] max_q, max_d;
  logic               in_dom, pass, take, xfer;
  logic [31:0]        square;

  assign vox_i.ready = push_ready_i;
  assign xfer = vox_i.valid && vox_i.ready;

  // domain test
  always_comb begin
    in_dom = (32'(vox_i.coord_x) < MaxDim) && (32'(vox_i.coord_y) < MaxDim) &&
             (32'(vox_i.coord_z) < MaxDim);
    case (cfg_i.domain_mode)
      DomWhole:  ;
      DomSliceX: if (vox_i.coord_x != cfg_i.slice_position) in_dom = 1'b0;
      DomSliceY: if (vox_i.coord_y != cfg_i.slice_position) in_dom = 1'b0;
      DomSliceZ: if (vox_i.coord_z != cfg_i.slice_position) in_dom = 1'b0;
      default:   in_dom = 1'b0;
    endcase
  end

  assign pass = (vox_i.label == cfg_i.selected_level) && (vox_i.label != '0) &&
                (vox_i.intensity != '0) && in_dom;
  assign take = pass && (count_q < LmisCountCap);
  assign square = 32'($signed(vox_i.intensity) * $signed(vox_i.intensity));

  // accumulator update for this voxel
  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sqsum_d = sqsum_q;
    min_d   = min_q;
    max_d   = max_q;
    if (take) begin
      count_d = count_q + 31'd1;
      sum_d   = sum_q + 46'(vox_i.intensity);
      sqsum_d = sqsum_q + 61'(square);
      if (vox_i.intensity < min_q) min_d = vox_i.intensity;
      if (vox_i.intensity > max_q) max_d = vox_i.intensity;
    end
  end

  // snapshot includes the last voxel itself
  assign push_o = xfer && vox_i.last_voxel;
  assign snap_o = '{count: count_d, sum: sum_d, square_sum: sqsum_d,
                    min_value: min_d, max_value: max_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      min_q   <= 16'sh7fff;
      max_q   <= 16'sh8000;
    end else if (xfer) begin
      if (vox_i.last_voxel) begin
        count_q <= '0;
        sum_q   <= '0;
        sqsum_q <= '0;
        min_q   <= 16'sh7fff;
        max_q   <= 16'sh8000;
      end else begin
        count_q <= count_d;
        sum_q   <= sum_d;
        sqsum_q <= sqsum_d;
        min_q   <= min_d;
        max_q   <= max_d;
      end
    end
  end

endmodule

// ----- rtl/lmis_queue.sv -----
// ----------------------------------------------------------------------------
// lmis_queue
// Short FIFO of accumulator snapshots between front and back.
// ----------------------------------------------------------------------------
module lmis_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lmis_pkg::lmis_snap_t push_data_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output lmis_pkg::lmis_snap_t pop_data_o,
  input  logic                 pop_i
);
  import lmis_pkg::*;

  localparam int unsigned PtrW = (LmisQueueDepth > 1) ? $clog2(LmisQueueDepth) : 1;

  lmis_snap_t       mem_q [LmisQueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    fill_q;
  logic             do_push, do_pop;

  assign push_ready_o = (fill_q != (PtrW+1)'(LmisQueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) wr_q <= (32'(wr_q) == LmisQueueDepth - 1) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (32'(rd_q) == LmisQueueDepth - 1) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      fill_q <= fill_q + 1'b1;
      else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= LmisQueueDepth) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_ready_o && !do_pop) |=> !push_ready_o) else $error("full queue lost entry");
  a_empty_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pop_valid_o && !do_push) |=> !pop_valid_o) else $error("empty queue gained entry");
`endif

endmodule

// ----- rtl/lmis_back.sv -----
// ----------------------------------------------------------------------------
// lmis_back
// Per-volume finisher: shift-add products, restoring divisions and a
// digit-by-digit square root, then a result register.
// ----------------------------------------------------------------------------
module lmis_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 snap_valid_i,
  input  lmis_pkg::lmis_snap_t snap_i,
  output logic                 pop_o,
  lmis_res_if.source           res_o
);
  import lmis_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul1 = 3'd1;
  localparam logic [2:0] SMul2 = 3'd2;
  localparam logic [2:0] SMul3 = 3'd3;
  localparam logic [2:0] SDivV = 3'd4;
  localparam logic [2:0] SDivM = 3'd5;
  localparam logic [2:0] SSqrt = 3'd6;
  localparam logic [2:0] SOut  = 3'd7;

  logic [2:0]   state_q, state_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         valid_q, valid_d;

  // operands of the current volume
  logic [30:0]  n_q, n_d;
  logic [45:0]  mag_q, mag_d;
  logic         neg_q, neg_d;
  // shift-add multiplier
  logic [91:0]  mc_q, mc_d, acc_q, acc_d, acc_nx;
  logic [45:0]  mp_q, mp_d;
  logic [90:0]  dif_q, dif_d;
  // restoring divider
  logic [106:0] num_q, num_d;
  logic [61:0]  rem_q, rem_d, den_q, den_d, rem_nx;
  logic [47:0]  quo_q, quo_d, quo_nx;
  logic [62:0]  trial;
  logic         ge;
  // square root
  logic [47:0]  sv_q, sv_d, sr_q, sr_d, sb_q, sb_d, sv_nx, sr_nx, sroot_t;
  // result fields
  logic [30:0]        r_cnt_q, r_cnt_d;
  logic signed [23:0] r_mean_q, r_mean_d;
  logic [23:0]        r_std_q, r_std_d;
  logic signed [15:0] r_min_q, r_min_d, r_max_q, r_max_d;

  assign res_o.valid       = valid_q;
  assign res_o.voxel_count = r_cnt_q;
  assign res_o.mean_q8     = r_mean_q;
  assign res_o.std_q8      = r_std_q;
  assign res_o.min_value   = r_min_q;
  assign res_o.max_value   = r_max_q;

  // one step of each unit
  assign acc_nx = acc_q + (mp_q[0] ? mc_q : 92'd0);
  assign trial  = {rem_q, num_q[106]};
  assign ge     = trial >= {1'b0, den_q};
  assign rem_nx = ge ? 62'(trial - {1'b0, den_q}) : trial[61:0];
  assign quo_nx = {quo_q[46:0], ge};
  assign sroot_t = sr_q + sb_q;
  always_comb begin
    if (sv_q >= sroot_t) begin
      sv_nx = sv_q - sroot_t;
      sr_nx = (sr_q >> 1) + sb_q;
    end else begin
      sv_nx = sv_q;
      sr_nx = sr_q >> 1;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  valid_d = valid_q;
    n_d = n_q;  mag_d = mag_q;  neg_d = neg_q;
    mc_d = mc_q;  mp_d = mp_q;  acc_d = acc_q;  dif_d = dif_q;
    num_d = num_q;  rem_d = rem_q;  den_d = den_q;  quo_d = quo_q;
    sv_d = sv_q;  sr_d = sr_q;  sb_d = sb_q;
    r_cnt_d = r_cnt_q;  r_mean_d = r_mean_q;  r_std_d = r_std_q;
    r_min_d = r_min_q;  r_max_d = r_max_q;
    pop_o = 1'b0;
    case (state_q)
      SIdle: begin
        if (snap_valid_i) begin
          pop_o   = 1'b1;
          n_d     = snap_i.count;
          neg_d   = snap_i.sum < 0;
          mag_d   = (snap_i.sum < 0) ? 46'(-snap_i.sum) : 46'(snap_i.sum);
          r_cnt_d = snap_i.count;
          r_min_d = snap_i.min_value;
          r_max_d = snap_i.max_value;
          if (snap_i.count == '0) begin
            r_mean_d = '0;  r_std_d = '0;  r_min_d = '0;  r_max_d = '0;
            valid_d  = 1'b1;
            state_d  = SOut;
          end else begin
            mc_d    = 92'(snap_i.square_sum);
            mp_d    = 46'(snap_i.count);
            acc_d   = '0;
            cnt_d   = 7'd30;
            state_d = SMul1;
          end
        end
      end
      SMul1, SMul2, SMul3: begin
        acc_d = acc_nx;
        mc_d  = mc_q << 1;
        mp_d  = mp_q >> 1;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          acc_d = '0;
          case (state_q)
            SMul1: begin
              dif_d = acc_nx[90:0];
              mc_d  = 92'(mag_q);  mp_d = mag_q;
              cnt_d = 7'd45;  state_d = SMul2;
            end
            SMul2: begin
              dif_d = dif_q - acc_nx[90:0];
              mc_d  = 92'(n_q);  mp_d = 46'(n_q);
              cnt_d = 7'd30;  state_d = SMul3;
            end
            default: begin
              den_d = acc_nx[61:0];
              num_d = {dif_q, 16'd0};
              rem_d = '0;  quo_d = '0;
              cnt_d = 7'd106;  state_d = SDivV;
            end
          endcase
        end
      end
      SDivV, SDivM: begin
        num_d = num_q << 1;
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          if (state_q == SDivV) begin
            sv_d  = quo_nx;
            num_d = {mag_q, 8'd0, 53'd0};
            den_d = 62'(n_q);
            rem_d = '0;  quo_d = '0;
            cnt_d = 7'd53;  state_d = SDivM;
          end else begin
            r_mean_d = neg_q ? 24'(-quo_nx[23:0]) : quo_nx[23:0];
            sr_d  = '0;
            sb_d  = 48'd1 << 46;
            cnt_d = 7'd23;  state_d = SSqrt;
          end
        end
      end
      SSqrt: begin
        sv_d  = sv_nx;
        sr_d  = sr_nx;
        sb_d  = sb_q >> 2;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          r_std_d = sr_nx[23:0];
          valid_d = 1'b1;
          state_d = SOut;
        end
      end
      SOut: begin
        if (res_o.ready) begin
          valid_d = 1'b0;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    n_q <= n_d;  mag_q <= mag_d;  neg_q <= neg_d;
    mc_q <= mc_d;  mp_q <= mp_d;  acc_q <= acc_d;  dif_q <= dif_d;
    num_q <= num_d;  rem_q <= rem_d;  den_q <= den_d;  quo_q <= quo_d;
    sv_q <= sv_d;  sr_q <= sr_d;  sb_q <= sb_d;
    r_cnt_q <= r_cnt_d;  r_mean_q <= r_mean_d;  r_std_q <= r_std_d;
    r_min_q <= r_min_d;  r_max_q <= r_max_d;
  end

`ifndef SYNTHESIS
  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == SOut)) else $error("result shown outside output state");
  a_root_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSqrt) |-> $onehot(sb_q)) else $error("root bit lost");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDivV || state_q == SDivM) |-> (rem_q < den_q))
    else $error("divider remainder out of range");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == SIdle && !valid_q)) else $error("pop while busy");
`endif

endmodule

// ----- rtl/label_masked_intensity_statistics.sv -----
// ----------------------------------------------------------------------------
// label_masked_intensity_statistics
// Count, Q8 mean, Q8 population std, min and max of one labeled region.
// ----------------------------------------------------------------------------
// Voxels are taken one per cycle; a voxel counts when its label equals
// selected_level, label and intensity are nonzero and it lies inside the
// volume and the chosen slice. The last voxel of a volume hands a snapshot of
// the accumulators to a two-entry queue and clears them, so the next volume
// streams on at once. A bit-serial finisher then turns each snapshot into a
// result (three shift-add products of 31, 46 and 31 steps, a 107-step and a
// 54-step restoring division, a 24-step square root, plus load and output),
// so volumes shorter than one finisher pass fill the queue and the voxel
// input stalls until an entry frees. Configuration goes through APB at
// addresses 0x0 (selected_level), 0x4 (domain_mode) and 0x8 (slice_position).
module label_masked_intensity_statistics #(
  parameter int unsigned MaxDim = lmis_pkg::LmisMaxDimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmis_vox_if.sink    vox_i,
  lmis_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lmis_pkg::*;

  lmis_cfg_t  cfg_q;
  lmis_snap_t push_snap, pop_snap;
  logic       push, push_ready, pop_valid, pop;
  logic       cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.selected_level <= 16'sd1;
      cfg_q.domain_mode    <= DomWhole;
      cfg_q.slice_position <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegSelectedLevel: cfg_q.selected_level <= pwdata[15:0];
        RegDomainMode:    cfg_q.domain_mode    <= lmis_domain_e'(pwdata[1:0]);
        RegSlicePosition: cfg_q.slice_position <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      RegSelectedLevel: prdata = {16'd0, cfg_q.selected_level};
      RegDomainMode:    prdata = {30'd0, cfg_q.domain_mode};
      RegSlicePosition: prdata = {22'd0, cfg_q.slice_position};
      default:          prdata = '0;
    endcase
  end

  lmis_front #(.MaxDim(MaxDim)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .vox_i        (vox_i),
    .push_o       (push),
    .snap_o       (push_snap),
    .push_ready_i (push_ready)
  );

  lmis_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_snap),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_snap),
    .pop_i        (pop)
  );

  lmis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (pop_valid),
    .snap_i       (pop_snap),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule
